### sv/dfbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfbm_pkg
// Shared types, constants and the byte blend function of the fader merger.
// ----------------------------------------------------------------------------
package dfbm_pkg;

  localparam int CHANNELS_DEFAULT = 513;
  localparam logic [7:0] LEVEL_MAX = 8'd255;

  typedef enum logic [2:0] {
    MODE_MAX     = 3'd0,
    MODE_EXCLUDE = 3'd1,
    MODE_SUB     = 3'd2,
    MODE_ADD     = 3'd3,
    MODE_AVG     = 3'd4,
    MODE_DIFF    = 3'd5
  } mode_t;

  // One fader touching a channel: who and with which mode.
  typedef struct packed {
    logic       hit;
    logic [5:0] fader;
    logic [2:0] mode;
  } touch_t;

  function automatic logic [7:0] blend(logic [7:0] acc, logic [7:0] lvl, logic [2:0] mode);
    logic [8:0] sum;
    logic [7:0] res;
    sum = {1'b0, acc} + {1'b0, lvl};
    unique case (mode)
      MODE_MAX:  res = (acc > lvl) ? acc : lvl;
      MODE_SUB:  res = (acc > lvl) ? acc - lvl : 8'd0;
      MODE_ADD:  res = sum[8] ? LEVEL_MAX : sum[7:0];
      MODE_AVG:  res = sum[8:1];
      MODE_DIFF: res = (acc > lvl) ? acc - lvl : lvl - acc;
      default:   res = acc;
    endcase
    return res;
  endfunction

endpackage

### sv/dfbm_blend_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfbm_blend_unit
// Blends one fader beat into the fader or sequence accumulator and decides
// whether the beat touches the channel.
// ----------------------------------------------------------------------------
module dfbm_blend_unit (
  input  logic                 first_of_channel,
  input  logic [7:0]           level,
  input  logic [2:0]           blend_mode,
  input  logic                 route,
  input  logic [7:0]           sequence_in,
  input  logic [5:0]           fader_index,
  input  logic [7:0]           fader_acc,
  input  logic [7:0]           sequence_acc,
  input  logic                 touched_flag,
  output logic [7:0]           fader_acc_next,
  output logic [7:0]           sequence_acc_next,
  output logic                 touched_flag_next,
  output dfbm_pkg::touch_t     touch
);

  logic [7:0] fader_base;
  logic [7:0] seq_base;
  logic [7:0] blended;
  logic       mode_ok;
  logic       level_on;
  logic       apply;
  logic       fader_quiet;

  // A new channel restarts both accumulators and the flag.
  assign fader_base = first_of_channel ? 8'd0 : fader_acc;
  assign seq_base   = first_of_channel ? sequence_in : sequence_acc;

  assign mode_ok  = (blend_mode != dfbm_pkg::MODE_EXCLUDE) &&
                    (blend_mode <= dfbm_pkg::MODE_DIFF);
  assign level_on = (level != 8'd0);

  // Subtract on the fader route applies even at zero level.
  assign apply = mode_ok && ((!route && blend_mode == dfbm_pkg::MODE_SUB) || level_on);

  // Max and subtract on the fader route never count as touching.
  assign fader_quiet = !route && (blend_mode == dfbm_pkg::MODE_MAX ||
                                  blend_mode == dfbm_pkg::MODE_SUB);

  assign blended = dfbm_pkg::blend(route ? seq_base : fader_base, level, blend_mode);

  assign fader_acc_next    = (apply && !route) ? blended : fader_base;
  assign sequence_acc_next = (apply && route) ? blended : seq_base;

  assign touch.hit   = mode_ok && level_on && !fader_quiet;
  assign touch.fader = fader_index;
  assign touch.mode  = blend_mode;

  assign touched_flag_next = touch.hit || (touched_flag && !first_of_channel);

endmodule

### sv/dfbm_toucher_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfbm_toucher_store
// Per-channel memory of the last touching fader and its mode, cleared by a
// sweep after reset, with a registered read and a same-beat bypass.
// ----------------------------------------------------------------------------
module dfbm_toucher_store #(
  parameter int CHANNELS = dfbm_pkg::CHANNELS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [9:0]       channel,
  input  logic             wr_en,
  input  dfbm_pkg::touch_t touch,
  input  logic             rd_en,
  output logic             clearing,
  output logic [5:0]       toucher_fader,
  output logic [2:0]       toucher_mode
);

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CHANNELS - 1);

  logic [8:0]        mem [CHANNELS];
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] addr;
  logic              in_range;
  logic [8:0]        rd_data;
  logic              rd_in_range;
  logic              rd_bypass;
  logic [8:0]        bypass_data;

  assign addr     = ADDR_W'(channel);
  assign in_range = (32'(channel) < 32'(CHANNELS));

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Read returns the value before this beat's write; the bypass covers it.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en && touch.hit && in_range) begin
      mem[addr] <= {touch.fader, touch.mode};
    end
    if (rd_en && in_range) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_in_range <= in_range;
      rd_bypass   <= touch.hit;
      bypass_data <= {touch.fader, touch.mode};
    end
  end

  always_comb begin
    priority if (!rd_in_range) begin
      {toucher_fader, toucher_mode} = 9'd0;
    end else if (rd_bypass) begin
      {toucher_fader, toucher_mode} = bypass_data;
    end else begin
      {toucher_fader, toucher_mode} = rd_data;
    end
  end

endmodule

### sv/dmx_fader_blend_merger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx_fader_blend_merger
// Merges per-fader DMX levels channel by channel into fader and sequence
// levels, and reports the last fader that touched each channel.
// ----------------------------------------------------------------------------
// Takes one fader beat per clock unless stalled by a waiting result or the
// sweep: a beat is registered, blended into the accumulators as it leaves the
// input register, and a channel's last beat loads the result register, which
// offers the result. The result register parts the two sides, so input keeps
// flowing while a result waits unless a second result is ready behind it.
// After reset the toucher memory is swept to zero, one channel per cycle over
// all CHANNELS entries, 513 by default, and item_ready stays low meanwhile.
module dmx_fader_blend_merger #(
  parameter int CHANNELS = dfbm_pkg::CHANNELS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [9:0] channel,
  input  logic [5:0] fader_index,
  input  logic [7:0] level,
  input  logic [2:0] blend_mode,
  input  logic       route,
  input  logic [7:0] sequence_in,
  input  logic       first_of_channel,
  input  logic       last_of_channel,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [9:0] out_channel,
  output logic [7:0] fader_value,
  output logic [7:0] sequence_value,
  output logic       touched,
  output logic [5:0] toucher_fader,
  output logic [2:0] toucher_mode
);

  // input register
  logic       a_valid;
  logic [9:0] a_channel;
  logic [5:0] a_fader;
  logic [7:0] a_level;
  logic [2:0] a_mode;
  logic       a_route;
  logic [7:0] a_seq;
  logic       a_first;
  logic       a_last;

  // accumulators
  logic [7:0] fader_acc;
  logic [7:0] sequence_acc;
  logic       touched_flag;
  logic [7:0] fader_acc_next;
  logic [7:0] sequence_acc_next;
  logic       touched_flag_next;

  // result register
  logic       b_valid;
  logic [9:0] b_channel;
  logic [7:0] b_fader;
  logic [7:0] b_seq;
  logic       b_touched;

  dfbm_pkg::touch_t touch;
  logic             a_adv;
  logic             load_b;
  logic             clearing;

  assign a_adv      = a_valid && (!a_last || !b_valid || result_ready);
  assign load_b     = a_adv && a_last;
  assign item_ready = !clearing && (!a_valid || a_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item_ready) begin
      a_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      a_channel <= channel;
      a_fader   <= fader_index;
      a_level   <= level;
      a_mode    <= blend_mode;
      a_route   <= route;
      a_seq     <= sequence_in;
      a_first   <= first_of_channel;
      a_last    <= last_of_channel;
    end
  end

  dfbm_blend_unit u_blend (
    .first_of_channel  (a_first),
    .level             (a_level),
    .blend_mode        (a_mode),
    .route             (a_route),
    .sequence_in       (a_seq),
    .fader_index       (a_fader),
    .fader_acc         (fader_acc),
    .sequence_acc      (sequence_acc),
    .touched_flag      (touched_flag),
    .fader_acc_next    (fader_acc_next),
    .sequence_acc_next (sequence_acc_next),
    .touched_flag_next (touched_flag_next),
    .touch             (touch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fader_acc    <= 8'd0;
      sequence_acc <= 8'd0;
      touched_flag <= 1'b0;
    end else if (a_adv) begin
      fader_acc    <= fader_acc_next;
      sequence_acc <= sequence_acc_next;
      touched_flag <= touched_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (load_b) begin
      b_valid <= 1'b1;
    end else if (result_ready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      b_channel <= a_channel;
      b_fader   <= fader_acc_next;
      b_seq     <= sequence_acc_next;
      b_touched <= touched_flag_next;
    end
  end

  dfbm_toucher_store #(
    .CHANNELS (CHANNELS)
  ) u_store (
    .clk           (clk),
    .rst           (rst),
    .channel       (a_channel),
    .wr_en         (a_adv),
    .touch         (touch),
    .rd_en         (load_b),
    .clearing      (clearing),
    .toucher_fader (toucher_fader),
    .toucher_mode  (toucher_mode)
  );

  assign result_valid   = b_valid;
  assign out_channel    = b_channel;
  assign fader_value    = b_fader;
  assign sequence_value = b_seq;
  assign touched        = b_touched;

`ifndef SYNTHESIS
  a_no_input_while_clearing : assert property (@(posedge clk) disable iff (rst)
    clearing |-> !item_ready)
    else $error("input accepted during memory sweep");

  a_sweep_after_reset : assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> clearing)
    else $error("memory sweep did not start after reset");

  a_stage_holds : assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_adv |=> a_valid && $stable(a_channel) && $stable(a_last))
    else $error("input register lost a stalled beat");

  a_out_of_range_zero : assert property (@(posedge clk) disable iff (rst)
    result_valid && (32'(out_channel) >= 32'(CHANNELS)) |->
      (toucher_fader == 6'd0) && (toucher_mode == 3'd0))
    else $error("toucher reported for channel outside the store");
`endif

endmodule
